// ===== hw/rtl/karq_pkg.sv =====
package karq_pkg;

    localparam int unsigned DELAY_W = 10;
    localparam int unsigned CODE_W  = 4;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;

    localparam logic [DELAY_W-1:0] INITIAL_DELAY_RST = 10'd150;
    localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST  = 10'd20;

    typedef enum logic {
        REG_INITIAL_DELAY = 1'b0,
        REG_REPEAT_DELAY  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [DELAY_W-1:0] initial_delay;
        logic [DELAY_W-1:0] repeat_delay;
    } karq_cfg_t;

endpackage

// ===== hw/rtl/karq_regs.sv =====
module karq_regs
    import karq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    output karq_cfg_t            cfg
);

    logic [DELAY_W-1:0] initial_delay_reg, initial_delay_next;
    logic [DELAY_W-1:0] repeat_delay_reg, repeat_delay_next;
    logic               wr_en;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[2]);

    always_comb begin
        initial_delay_next = initial_delay_reg;
        repeat_delay_next  = repeat_delay_reg;
        if (wr_en) begin
            unique case (idx)
                REG_INITIAL_DELAY: initial_delay_next = pwdata[DELAY_W-1:0];
                REG_REPEAT_DELAY:  repeat_delay_next  = pwdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_INITIAL_DELAY: prdata = {{(APB_DW-DELAY_W){1'b0}}, initial_delay_reg};
            REG_REPEAT_DELAY:  prdata = {{(APB_DW-DELAY_W){1'b0}}, repeat_delay_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_delay_reg <= INITIAL_DELAY_RST;
            repeat_delay_reg  <= REPEAT_DELAY_RST;
        end else begin
            initial_delay_reg <= initial_delay_next;
            repeat_delay_reg  <= repeat_delay_next;
        end
    end

    assign cfg.initial_delay = initial_delay_reg;
    assign cfg.repeat_delay  = repeat_delay_reg;

endmodule

// ===== hw/rtl/karq_core.sv =====
module karq_core
    import karq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  karq_cfg_t            cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_key_down,
    input  logic [CODE_W-1:0]    s_key_code,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CODE_W-1:0]    m_key_out
);

    logic                arming_reg, arming_next;
    logic                held_valid_reg, held_valid_next;
    logic [CODE_W-1:0]   held_code_reg, held_code_next;
    logic [DELAY_W-1:0]  countdown_reg, countdown_next;
    logic                rpt_valid_reg, rpt_valid_next;
    logic [CODE_W-1:0]   rpt_code_reg, rpt_code_next;
    logic                out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]   out_code_reg, out_code_next;
    logic                accept;
    logic                emit;

    // output slot is free when empty or being drained this cycle
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        arming_next     = arming_reg;
        held_valid_next = held_valid_reg;
        held_code_next  = held_code_reg;
        countdown_next  = countdown_reg;
        rpt_valid_next  = rpt_valid_reg;
        rpt_code_next   = rpt_code_reg;
        emit            = 1'b0;
        if (accept) begin
            if (!s_key_down) begin
                held_valid_next = 1'b0;
                rpt_valid_next  = 1'b0;
                arming_next     = 1'b0;
            end else if (arming_reg) begin
                held_valid_next = 1'b1;
                held_code_next  = s_key_code;
                countdown_next  = (rpt_valid_reg && rpt_code_reg == s_key_code)
                                  ? cfg.repeat_delay : cfg.initial_delay;
                arming_next     = 1'b0;
            end else if (held_valid_reg && held_code_reg == s_key_code) begin
                if (countdown_reg <= DELAY_W'(1)) begin
                    countdown_next = '0;
                    rpt_valid_next = 1'b1;
                    rpt_code_next  = s_key_code;
                    arming_next    = 1'b1;
                    emit           = 1'b1;
                end else begin
                    countdown_next = countdown_reg - DELAY_W'(1);
                end
            end else begin
                // different key, or no key held: emitted at once
                arming_next = 1'b1;
                emit        = 1'b1;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_code_next  = out_code_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_code_next  = s_key_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arming_reg     <= 1'b1;
            held_valid_reg <= 1'b0;
            held_code_reg  <= '0;
            countdown_reg  <= '0;
            rpt_valid_reg  <= 1'b0;
            rpt_code_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            arming_reg     <= arming_next;
            held_valid_reg <= held_valid_next;
            held_code_reg  <= held_code_next;
            countdown_reg  <= countdown_next;
            rpt_valid_reg  <= rpt_valid_next;
            rpt_code_reg   <= rpt_code_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_code_reg <= out_code_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_key_out = out_code_reg;

endmodule

// ===== hw/rtl/key_auto_repeat_qualifier_unit.sv =====
// Typematic auto-repeat for a scanned keypad. Each request is one scan sample
// (s_key_down, s_key_code); a key event appears on m_key_out when a new key is
// pressed or a held key has counted down initial_delay (first) or repeat_delay
// (later) matching samples. The sample right after an event only arms the
// tracker. One sample is taken each cycle; an event shows up in the cycle after
// its sample from the output register, and s_ready drops only while that
// register holds an event that the sink has not taken. Delays are written
// over the APB port: initial_delay at 0x0, repeat_delay at 0x4 (10 bits each).
module key_auto_repeat_qualifier_unit
    import karq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_key_down,
    input  logic [CODE_W-1:0]    s_key_code,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CODE_W-1:0]    m_key_out
);

    karq_cfg_t cfg;

    karq_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    karq_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_key_down (s_key_down),
        .s_key_code (s_key_code),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_key_out  (m_key_out)
    );

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import karq_pkg::*;

    // Predicts key events from accepted scan samples and checks them in order.
    class key_event_scoreboard;
        logic [DELAY_W-1:0] init_d;
        logic [DELAY_W-1:0] rep_d;
        bit                 arming;
        bit                 held_v;
        logic [CODE_W-1:0]  held_c;
        logic [DELAY_W-1:0] count;
        bit                 rep_v;
        logic [CODE_W-1:0]  rep_c;
        logic [CODE_W-1:0]  key_events[$];
        int                 mismatches;

        function new();
            init_d     = INITIAL_DELAY_RST;
            rep_d      = REPEAT_DELAY_RST;
            arming     = 1'b1;
            held_v     = 1'b0;
            held_c     = '0;
            count      = '0;
            rep_v      = 1'b0;
            rep_c      = '0;
            mismatches = 0;
        endfunction

        function void set_delay(reg_idx_t idx, logic [DELAY_W-1:0] v);
            if (idx == REG_INITIAL_DELAY) begin
                init_d = v;
            end else begin
                rep_d = v;
            end
        endfunction

        function void report_mismatch(string what, int exp_v, int got_v);
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH %s: expected %0d, got %0d", what, exp_v, got_v);
            end
        endfunction

        function void note_sample(logic dn, logic [CODE_W-1:0] cd);
            if (!dn) begin
                // release drops both the tracked key and the repeating key
                held_v = 1'b0;
                rep_v  = 1'b0;
                arming = 1'b0;
            end else if (arming) begin
                held_v = 1'b1;
                held_c = cd;
                count  = (rep_v && rep_c == cd) ? rep_d : init_d;
                arming = 1'b0;
            end else if (held_v && held_c == cd) begin
                if (count <= 1) begin
                    count  = '0;
                    rep_v  = 1'b1;
                    rep_c  = cd;
                    arming = 1'b1;
                    key_events.push_back(cd);
                end else begin
                    count = count - 1'b1;
                end
            end else begin
                arming = 1'b1;
                key_events.push_back(cd);
            end
        endfunction

        function void check_event(logic [CODE_W-1:0] got);
            logic [CODE_W-1:0] want;
            if (key_events.size() == 0) begin
                report_mismatch("key_out (no event pending)", -1, got);
            end else begin
                want = key_events.pop_front();
                if (got !== want) begin
                    report_mismatch("key_out", want, got);
                end
            end
        endfunction

        function int outstanding();
            return key_events.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn    = 1'b0;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [APB_AW-1:0]   paddr      = '0;
    logic [APB_DW-1:0]   pwdata     = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_valid    = 1'b0;
    logic                s_ready;
    logic                s_key_down = 1'b0;
    logic [CODE_W-1:0]   s_key_code = '0;
    logic                m_valid;
    logic                m_ready    = 1'b0;
    logic [CODE_W-1:0]   m_key_out;

    key_event_scoreboard scb = new();
    bit                  idle_on       = 1'b0;
    bit                  long_hold_req = 1'b0;

    key_auto_repeat_qualifier_unit uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_key_down (s_key_down),
        .s_key_code (s_key_code),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_key_out  (m_key_out)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

    // Result sink: random stall bursts, plus one long hold-off on request.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                scb.check_event(m_key_out);
            end
            if (long_hold_req) begin
                stall_left    = 80;
                long_hold_req = 1'b0;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 14);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Write a delay register, then read it back.
    task automatic apb_write(input reg_idx_t idx, input logic [DELAY_W-1:0] v);
        logic [APB_AW-1:0] addr;
        addr = {idx, 2'b00};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {22'($urandom), v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        scb.set_delay(idx, v);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[DELAY_W-1:0] !== v) begin
            scb.report_mismatch("register readback", v, prdata[DELAY_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_sample(input logic dn, input logic [CODE_W-1:0] cd);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_key_down <= dn;
        s_key_code <= cd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        scb.note_sample(dn, cd);
    endtask

    task automatic hold_key(input logic [CODE_W-1:0] cd, input int n);
        repeat (n) send_sample(1'b1, cd);
    endtask

    // Park the source and let the block drain before touching registers.
    task automatic settle(input int tail);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (scb.outstanding() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    // Mostly held keys sized around the delays, with noise and releases mixed in.
    task automatic scan_traffic(input int n_items);
        int                sent;
        int                len;
        int                pick;
        int                cyc_i;
        int                cyc_r;
        logic [CODE_W-1:0] cd;
        sent = 0;
        while (sent < n_items) begin
            pick  = $urandom_range(0, 99);
            cd    = CODE_W'($urandom);
            cyc_i = 1 + ((scb.init_d == 0) ? 1 : int'(scb.init_d));
            cyc_r = 1 + ((scb.rep_d == 0) ? 1 : int'(scb.rep_d));
            if (pick < 60) begin
                if ($urandom_range(0, 2) == 0) begin
                    len = $urandom_range(1, 6);
                end else begin
                    len = cyc_i + $urandom_range(0, 3) * cyc_r + $urandom_range(0, 4) - 2;
                end
                if (len < 1) len = 1;
                if (len > n_items - sent) len = n_items - sent;
                hold_key(cd, len);
                sent += len;
                if ($urandom_range(0, 1) == 0) begin
                    send_sample(1'b0, CODE_W'($urandom));
                    sent++;
                end
            end else if (pick < 85) begin
                len = $urandom_range(1, 8);
                repeat (len) send_sample(1'($urandom), CODE_W'($urandom));
                sent += len;
            end else begin
                len = $urandom_range(1, 3);
                repeat (len) send_sample(1'b0, CODE_W'($urandom));
                sent += len;
            end
        end
    endtask

    initial begin : stimulus
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on = 1'b1;

        // reset delays: release while arming, immediate keys, release while tracking
        send_sample(1'b0, 4'hF);
        send_sample(1'b1, 4'h0);
        send_sample(1'b1, 4'hF);
        send_sample(1'b1, 4'h0);
        send_sample(1'b0, 4'h0);
        send_sample(1'b1, 4'hA);
        hold_key(4'hA, 4);
        send_sample(1'b0, 4'h5);
        send_sample(1'b1, 4'h5);
        send_sample(1'b1, 4'h5);
        send_sample(1'b1, 4'h3);
        send_sample(1'b1, 4'hC);
        send_sample(1'b1, 4'hC);
        scan_traffic(200);
        settle(4);

        // minimum delays; the sink also holds off long enough to back up the input
        apb_write(REG_INITIAL_DELAY, 10'd1);
        apb_write(REG_REPEAT_DELAY, 10'd1);
        hold_key(4'h9, 8);
        long_hold_req = 1'b1;
        scan_traffic(150);
        settle(4);

        // zero delays run out on the first match
        apb_write(REG_INITIAL_DELAY, 10'd0);
        apb_write(REG_REPEAT_DELAY, 10'd0);
        hold_key(4'h6, 6);
        scan_traffic(100);
        settle(4);

        // maximum delays: one long hold reaches the first emission
        apb_write(REG_INITIAL_DELAY, 10'd1023);
        apb_write(REG_REPEAT_DELAY, 10'd1023);
        send_sample(1'b0, 4'h0);
        hold_key(4'hE, 1030);
        send_sample(1'b0, 4'h1);
        settle(4);

        // no idling in the last part
        idle_on = 1'b0;
        apb_write(REG_INITIAL_DELAY, 10'd12);
        apb_write(REG_REPEAT_DELAY, 10'd3);
        scan_traffic(150);
        settle(10);

        if (scb.mismatches == 0 && scb.outstanding() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== key_auto_repeat_qualifier_unit.f =====
hw/rtl/karq_pkg.sv
hw/rtl/karq_regs.sv
hw/rtl/karq_core.sv
hw/rtl/key_auto_repeat_qualifier_unit.sv
verif/testbench.sv
